// ----- rtl/rrva_pkg.sv -----
// ----------------------------------------------------------------------------
// rrva_pkg
// Shared constants, types and helpers of the round-robin voice allocator.
// ----------------------------------------------------------------------------
package rrva_pkg;

	localparam int VOICES  = 16;
	localparam int VIDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int MASK_N  = (VOICES < 16) ? VOICES : 16;
	localparam int Q_DEPTH = 2;
	localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	localparam logic [1:0] KIND_ON   = 2'd0;
	localparam logic [1:0] KIND_OFF  = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;

	localparam logic [1:0] OP_ON   = 2'd0;
	localparam logic [1:0] OP_OFF  = 2'd1;
	localparam logic [1:0] OP_DONE = 2'd2;
	localparam logic [1:0] OP_NOP  = 2'd3;

	typedef struct packed {
		logic [1:0]        kind;
		logic [1:0]        op;
		logic [6:0]        note;
		logic [6:0]        velocity;
		logic [VIDX_W-1:0] vidx;
	} req_t;

	typedef struct packed {
		logic        valid;
		logic [1:0]  event_kind;
		logic [3:0]  voice;
		logic        stolen;
		logic [6:0]  start_note;
		logic [6:0]  start_velocity;
		logic [15:0] release_mask;
	} result_t;

	function automatic logic [VIDX_W-1:0] adv(input logic [VIDX_W-1:0] v);
		return (v == VIDX_W'(VOICES - 1)) ? '0 : v + 1'b1;
	endfunction

endpackage

// ----- rtl/rrva_front.sv -----
// ----------------------------------------------------------------------------
// rrva_front
// Accepts requests and classifies them into operations for the back end.
// ----------------------------------------------------------------------------
module rrva_front import rrva_pkg::*; (
	input  logic       start,
	input  logic [1:0] kind,
	input  logic [6:0] note,
	input  logic [6:0] velocity,
	input  logic [3:0] done_voice,
	input  logic       q_full,
	output logic       busy,
	output logic       push,
	output req_t       push_req
);

	always_comb begin
		busy              = q_full;
		push              = start && !q_full;
		push_req.kind     = kind;
		push_req.note     = note;
		push_req.velocity = velocity;
		push_req.vidx     = VIDX_W'(done_voice);
		case (kind)
			KIND_ON:   push_req.op = OP_ON;
			KIND_OFF:  push_req.op = OP_OFF;
			KIND_DONE: push_req.op = (32'(done_voice) < VOICES) ? OP_DONE : OP_NOP;
			default:   push_req.op = OP_NOP;
		endcase
	end

endmodule

// ----- rtl/rrva_queue.sv -----
// ----------------------------------------------------------------------------
// rrva_queue
// Short request FIFO between front and back end.
// ----------------------------------------------------------------------------
module rrva_queue import rrva_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  req_t push_req,
	input  logic pop,
	output req_t pop_req,
	output logic full,
	output logic empty
);

	req_t              slot_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	function automatic logic [QPTR_W-1:0] nxt(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full    = (cnt_q == QCNT_W'(Q_DEPTH));
	assign empty   = (cnt_q == '0);
	assign pop_req = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= nxt(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= nxt(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/rrva_back.sv -----
// ----------------------------------------------------------------------------
// rrva_back
// Voice state and sequencer: round-robin scan, note-off match, voice done.
// ----------------------------------------------------------------------------
module rrva_back import rrva_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_empty,
	input  req_t    q_req,
	output logic    pop,
	output result_t res
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ON   = 2'd1;
	localparam logic [1:0] ST_OFF  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]        state_q;
	req_t              cur_q;
	logic [VOICES-1:0] playing_q;
	logic [VOICES-1:0] assigned_q;
	logic [VIDX_W-1:0] next_voice_q;
	logic [VIDX_W-1:0] p_q;
	logic [VIDX_W-1:0] cnt_q;
	logic              iss_q;
	logic              vld_s1;
	logic [VIDX_W-1:0] idx_s1;
	logic [6:0]        rd_note_s1;
	logic [15:0]       mask_q;
	result_t           res_q;

	logic [6:0]        note_mem [VOICES];

	logic              on_free;
	logic              on_fin;
	logic [VIDX_W-1:0] pv;
	logic              off_hit;
	logic              off_fin;
	logic [15:0]       mask_nxt;

	always_comb begin
		on_free  = !playing_q[p_q];
		pv       = on_free ? p_q : adv(p_q);
		on_fin   = (state_q == ST_ON) && (on_free || (cnt_q == VIDX_W'(VOICES - 1)));
		off_hit  = assigned_q[idx_s1] && (rd_note_s1 == cur_q.note);
		mask_nxt = mask_q | (off_hit ? (16'd1 << idx_s1) : 16'd0);
		off_fin  = (state_q == ST_OFF) && vld_s1 && (idx_s1 == VIDX_W'(MASK_N - 1));
		pop      = (state_q == ST_IDLE) && !q_empty;
	end

	assign res = res_q;

	always_ff @(posedge clk) begin
		if (on_fin) begin
			note_mem[pv] <= cur_q.note;
		end
		rd_note_s1 <= note_mem[cnt_q];
		idx_s1     <= cnt_q;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_req;
		end
		if (state_q == ST_IDLE) begin
			mask_q <= '0;
		end else if (state_q == ST_OFF && vld_s1) begin
			mask_q <= mask_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			playing_q    <= '0;
			assigned_q   <= '0;
			next_voice_q <= '0;
			p_q          <= '0;
			cnt_q        <= '0;
			iss_q        <= 1'b0;
			vld_s1       <= 1'b0;
			res_q        <= '0;
		end else begin
			res_q.valid          <= on_fin || off_fin || (state_q == ST_FIN);
			res_q.event_kind     <= cur_q.kind;
			res_q.voice          <= '0;
			res_q.stolen         <= 1'b0;
			res_q.start_note     <= '0;
			res_q.start_velocity <= '0;
			res_q.release_mask   <= '0;
			if (on_fin) begin
				res_q.voice          <= 4'(pv);
				res_q.stolen         <= !on_free;
				res_q.start_note     <= cur_q.note;
				res_q.start_velocity <= cur_q.velocity;
			end
			if (off_fin) begin
				res_q.release_mask <= mask_nxt;
			end
			vld_s1      <= (state_q == ST_OFF) && iss_q;
			case (state_q)
				ST_IDLE: begin
					p_q   <= next_voice_q;
					cnt_q <= '0;
					iss_q <= 1'b1;
					if (pop) begin
						case (q_req.op)
							OP_ON:   state_q <= ST_ON;
							OP_OFF:  state_q <= ST_OFF;
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_ON: begin
					if (on_fin) begin
						playing_q[pv]  <= 1'b1;
						assigned_q[pv] <= 1'b1;
						next_voice_q   <= adv(pv);
						state_q        <= ST_IDLE;
					end else begin
						p_q   <= adv(p_q);
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_OFF: begin
					if (iss_q) begin
						if (cnt_q == VIDX_W'(MASK_N - 1)) begin
							iss_q <= 1'b0;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
					if (off_fin) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FIN: begin
					if (cur_q.op == OP_DONE) begin
						playing_q[cur_q.vidx] <= 1'b0;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/round_robin_voice_allocator_core.sv -----
// ----------------------------------------------------------------------------
// round_robin_voice_allocator_core
// Round-robin polyphonic voice allocator with voice stealing.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy rises only when
// the two-entry request queue is full. Every request yields exactly one result,
// shown for one cycle with result_valid high, in request order; the receiver
// cannot stall, so results must be taken as they appear. The back-end
// sequencer handles one request at a time: a note-on scans one voice a cycle
// from the round-robin pointer, a note-off reads the first MASK_N entries of
// the note store one voice a cycle, and a voice-done or unused request is
// handled without a scan.
module round_robin_voice_allocator_core import rrva_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [6:0]  note,
	input  logic [6:0]  velocity,
	input  logic [3:0]  done_voice,
	output logic        result_valid,
	output logic [1:0]  event_kind,
	output logic [3:0]  voice,
	output logic        stolen,
	output logic [6:0]  start_note,
	output logic [6:0]  start_velocity,
	output logic [15:0] release_mask
);

	logic    q_full;
	logic    q_empty;
	logic    push;
	logic    pop;
	req_t    push_req;
	req_t    pop_req;
	result_t res;

	rrva_front u_front (
		.start      (start),
		.kind       (kind),
		.note       (note),
		.velocity   (velocity),
		.done_voice (done_voice),
		.q_full     (q_full),
		.busy       (busy),
		.push       (push),
		.push_req   (push_req)
	);

	rrva_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_req (push_req),
		.pop      (pop),
		.pop_req  (pop_req),
		.full     (q_full),
		.empty    (q_empty)
	);

	rrva_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_req   (pop_req),
		.pop     (pop),
		.res     (res)
	);

	assign result_valid   = res.valid;
	assign event_kind     = res.event_kind;
	assign voice          = res.voice;
	assign stolen         = res.stolen;
	assign start_note     = res.start_note;
	assign start_velocity = res.start_velocity;
	assign release_mask   = res.release_mask;

endmodule

// ----- rtl/rrva_checker.sv -----
// ----------------------------------------------------------------------------
// rrva_checker
// Port-level checks of the voice allocator, bound to the top level.
// ----------------------------------------------------------------------------
module rrva_checker import rrva_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        result_valid,
	input logic [1:0]  event_kind,
	input logic [3:0]  voice,
	input logic        stolen,
	input logic [6:0]  start_note,
	input logic [6:0]  start_velocity,
	input logic [15:0] release_mask
);

	a_strobe_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("back-to-back result strobes");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a request");

	a_on_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && event_kind != KIND_ON) |->
		(voice == '0 && !stolen && start_note == '0 && start_velocity == '0))
		else $error("note-on fields set on another kind");

	a_off_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && event_kind != KIND_OFF) |-> (release_mask == '0))
		else $error("release mask set on another kind");

endmodule

bind round_robin_voice_allocator_core rrva_checker u_rrva_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.result_valid   (result_valid),
	.event_kind     (event_kind),
	.voice          (voice),
	.stolen         (stolen),
	.start_note     (start_note),
	.start_velocity (start_velocity),
	.release_mask   (release_mask)
);
